>>> hdl/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg
// shared types and constants for the json pretty-print formatter
// ----------------------------------------------------------------------------
package jpp_pkg;

  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned INDENT_W = 4;
  localparam int unsigned SPACES_W = 10;
  localparam int unsigned PROD_W   = LEVEL_W + INDENT_W;

  // deepest nesting level that is still counted
  localparam logic [LEVEL_W-1:0]  MAX_DEPTH      = 7'd64;
  localparam logic [SPACES_W-1:0] SPACES_MAX     = 10'd1023;
  localparam logic [INDENT_W-1:0] INDENT_DEFAULT = 4'd2;

  // bytes with a meaning to the formatter
  localparam logic [7:0] CH_NONE      = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COMMA     = 8'h2C;

  typedef struct packed {
    logic [7:0] in_char;
    logic       text_start;
  } item_t;

  typedef struct packed {
    logic                newline_before;
    logic [SPACES_W-1:0] spaces_before;
    logic [7:0]          out_char;
    logic                space_after;
    logic                depth_fault;
  } token_t;

endpackage

>>> hdl/jpp_core.sv
// ----------------------------------------------------------------------------
// jpp_core
// formatter state and the per-byte token logic, one byte per enable
// ----------------------------------------------------------------------------
module jpp_core import jpp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [INDENT_W-1:0] cfg_wdata,
  input  logic                step,
  input  item_t               item,
  output token_t              token
);

  logic [INDENT_W-1:0] indent_width;
  logic [LEVEL_W-1:0]  nest_level, nest_level_next;
  logic                in_string, in_string_next;
  logic                escape_pending, escape_pending_next;
  logic                line_start_pending, line_start_pending_next;
  logic [7:0]          previous_byte;

  logic [LEVEL_W-1:0]  cur_level;
  logic                cur_in_string, cur_escape, cur_line_start;
  logic [7:0]          cur_prev;
  logic [PROD_W-1:0]   prod;
  logic [SPACES_W-1:0] indent_spaces;
  logic [7:0]          c;

  // start of a new text sees cleared state
  always_comb begin
    c              = item.in_char;
    cur_level      = item.text_start ? '0 : nest_level;
    cur_in_string  = item.text_start ? 1'b0 : in_string;
    cur_escape     = item.text_start ? 1'b0 : escape_pending;
    cur_line_start = item.text_start ? 1'b0 : line_start_pending;
    cur_prev       = item.text_start ? CH_NONE : previous_byte;
  end

  // narrow 7x4 product, saturated to the field width
  always_comb begin
    prod = PROD_W'(cur_level) * PROD_W'(indent_width);
    if (prod > PROD_W'(SPACES_MAX)) begin
      indent_spaces = SPACES_MAX;
    end else begin
      indent_spaces = prod[SPACES_W-1:0];
    end
  end

  always_comb begin
    nest_level_next         = cur_level;
    in_string_next          = cur_in_string;
    escape_pending_next     = 1'b0;
    line_start_pending_next = cur_line_start;
    token                   = '0;
    token.out_char          = c;
    case (c)
      CH_BACKSLASH: begin
        escape_pending_next = !cur_escape && cur_in_string;
      end
      CH_COLON: begin
        token.space_after = !cur_in_string;
      end
      CH_QUOTE: begin
        if (cur_line_start) begin
          token.newline_before    = 1'b1;
          token.spaces_before     = indent_spaces;
          line_start_pending_next = 1'b0;
        end
        if (!cur_escape) begin
          in_string_next = !cur_in_string;
        end
      end
      CH_LBRACE, CH_LBRACKET: begin
        if (!cur_in_string) begin
          if (cur_level >= MAX_DEPTH) begin
            token.depth_fault = 1'b1;
          end else begin
            nest_level_next = cur_level + 1'b1;
          end
          line_start_pending_next = 1'b1;
        end
      end
      CH_RBRACE, CH_RBRACKET: begin
        if (!cur_in_string) begin
          // empty container closes on the same line
          token.newline_before = (cur_prev != CH_LBRACKET) && (cur_prev != CH_LBRACE);
          if (cur_level == '0) begin
            token.depth_fault = 1'b1;
          end else begin
            nest_level_next = cur_level - 1'b1;
          end
          // indent is for the depth after the close
          if (!cur_line_start) begin
            token.spaces_before = ((PROD_W'(nest_level_next) * PROD_W'(indent_width))
                                   > PROD_W'(SPACES_MAX))
                                  ? SPACES_MAX
                                  : SPACES_W'(PROD_W'(nest_level_next)
                                              * PROD_W'(indent_width));
          end
          line_start_pending_next = 1'b0;
        end
      end
      CH_COMMA: begin
        if (!cur_in_string) begin
          line_start_pending_next = 1'b1;
        end
      end
      default: begin
        if (cur_line_start) begin
          token.newline_before    = 1'b1;
          token.spaces_before     = indent_spaces;
          line_start_pending_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      indent_width <= INDENT_DEFAULT;
    end else if (cfg_we) begin
      indent_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nest_level         <= '0;
      in_string          <= 1'b0;
      escape_pending     <= 1'b0;
      line_start_pending <= 1'b0;
      previous_byte      <= CH_NONE;
    end else if (step) begin
      nest_level         <= nest_level_next;
      in_string          <= in_string_next;
      escape_pending     <= escape_pending_next;
      line_start_pending <= line_start_pending_next;
      previous_byte      <= c;
    end
  end

endmodule

>>> hdl/json_pretty_print_formatter.sv
// ----------------------------------------------------------------------------
// json_pretty_print_formatter
// turns compact json text, one byte per transaction, into formatting tokens
// ----------------------------------------------------------------------------
// path: input register, core logic, then result register; a stall on the token
//   side holds the token in the result register and the byte in the input register
// throughput: one byte per cycle while token_stall is low, set by the state update loop
// reset: synchronous; clears both stages, all nesting state, indent width 2
// ----------------------------------------------------------------------------
module json_pretty_print_formatter import jpp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // configuration: indent width
  input  logic                cfg_we,
  input  logic [INDENT_W-1:0] cfg_wdata,
  // byte stream in
  input  logic                item_valid,
  output logic                item_stall,
  input  item_t               item,
  // token stream out
  output logic                token_valid,
  input  logic                token_stall,
  output token_t              token
);

  // input stage
  logic   in_q_valid;
  item_t  in_q;

  // result stage
  token_t core_token;
  logic   out_free;
  logic   advance;
  logic   accept;

  // result register can take a new token when empty or being drained
  assign out_free   = !token_valid || !token_stall;
  // byte in the input register moves through the core into the result register
  assign advance    = in_q_valid && out_free;
  // input register frees up whenever its byte advances
  assign item_stall = in_q_valid && !out_free;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= item;
    end
  end

  // state machine for nesting, strings, escapes and line starts
  jpp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (in_q),
    .token     (core_token)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (advance) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  // token holds while stalled since advance needs out_free
  always_ff @(posedge clk) begin
    if (advance) begin
      token <= core_token;
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the json pretty-print formatter: a short table of
// hand-picked bytes, then generated json texts (nested documents, deep bracket
// runs that may cross either depth limit, damaged texts and raw byte noise) under
// several indent widths, with random gaps on both streams; every token is
// compared field by field against a typed-in token or an in-bench model of the formatter
// ----------------------------------------------------------------------------
module tb import jpp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // random transactions per indent width
  localparam int unsigned RAND_PER_PHASE = 200;
  localparam int unsigned NUM_PHASES     = 6;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [INDENT_W-1:0] cfg_wdata;
  logic                item_valid;
  logic                item_stall;
  item_t               item;
  logic                token_valid;
  logic                token_stall;
  token_t              token;

  json_pretty_print_formatter u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  // formatter model state, kept in step with accepted bytes
  logic [INDENT_W-1:0] pp_indent;
  logic [LEVEL_W-1:0]  pp_level;
  logic                pp_in_string;
  logic                pp_escape;
  logic                pp_line_start;
  logic [7:0]          pp_prev_char;

  token_t      tokens_due [$];
  logic [7:0]  text_buf [$];
  int unsigned items_sent;
  int unsigned err_cnt;
  // when set, that side runs without gaps for the current text
  bit          calm_send;
  bit          calm_recv;
  string       scalar_set = "0123456789-.eEtrufalsn";

  // directed table: byte, text start, expectation typed in, expected token
  typedef struct packed {
    logic [7:0] ch;
    logic       st;
    logic       typed;
    token_t     tok;
  } dir_row_t;

  dir_row_t dir_tab [0:24] = '{
    // first byte of a text opens an object, no newline
    {CH_LBRACE,    1'b1, 1'b1, 1'b0, 10'd0, CH_LBRACE,    1'b0, 1'b0},
    // key quote takes the pending line start at depth 1
    {CH_QUOTE,     1'b0, 1'b1, 1'b1, 10'd2, CH_QUOTE,     1'b0, 1'b0},
    {8'h61,        1'b0, 1'b0, 21'd0},
    // backslash in a string starts an escape
    {CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 10'd0, CH_BACKSLASH, 1'b0, 1'b0},
    // escaped quote stays inside the string
    {CH_QUOTE,     1'b0, 1'b1, 1'b0, 10'd0, CH_QUOTE,     1'b0, 1'b0},
    {CH_QUOTE,     1'b0, 1'b0, 21'd0},
    // colon outside a string gets a trailing space
    {CH_COLON,     1'b0, 1'b1, 1'b0, 10'd0, CH_COLON,     1'b1, 1'b0},
    {CH_LBRACKET,  1'b0, 1'b0, 21'd0},
    // empty array: no newline, line start pending so no indent
    {CH_RBRACKET,  1'b0, 1'b1, 1'b0, 10'd0, CH_RBRACKET,  1'b0, 1'b0},
    {CH_COMMA,     1'b0, 1'b0, 21'd0},
    // top byte value as an ordinary byte after a comma
    {8'hFF,        1'b0, 1'b1, 1'b1, 10'd2, 8'hFF,        1'b0, 1'b0},
    {CH_NONE,      1'b0, 1'b0, 21'd0},
    // close back to depth 0
    {CH_RBRACE,    1'b0, 1'b1, 1'b1, 10'd0, CH_RBRACE,    1'b0, 1'b0},
    // close at depth 0 underflows
    {CH_RBRACKET,  1'b0, 1'b1, 1'b1, 10'd0, CH_RBRACKET,  1'b0, 1'b1},
    // new text: backslash outside a string is plain
    {CH_BACKSLASH, 1'b1, 1'b1, 1'b0, 10'd0, CH_BACKSLASH, 1'b0, 1'b0},
    {CH_COLON,     1'b0, 1'b0, 21'd0},
    {CH_QUOTE,     1'b0, 1'b0, 21'd0},
    // brackets and colons inside a string are plain
    {CH_LBRACE,    1'b0, 1'b0, 21'd0},
    {CH_COLON,     1'b0, 1'b1, 1'b0, 10'd0, CH_COLON,     1'b0, 1'b0},
    // escaped backslash, then the quote really closes
    {CH_BACKSLASH, 1'b0, 1'b0, 21'd0},
    {CH_BACKSLASH, 1'b0, 1'b0, 21'd0},
    {CH_QUOTE,     1'b0, 1'b0, 21'd0},
    // backslash outside a string leaves the line start pending
    {CH_COMMA,     1'b0, 1'b0, 21'd0},
    {CH_BACKSLASH, 1'b0, 1'b0, 21'd0},
    {CH_RBRACE,    1'b0, 1'b0, 21'd0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic void clear_nesting();
    pp_level      = '0;
    pp_in_string  = 1'b0;
    pp_escape     = 1'b0;
    pp_line_start = 1'b0;
    pp_prev_char  = CH_NONE;
  endfunction

  // depth times indent width, saturated to the field
  function automatic logic [SPACES_W-1:0] indent_now();
    int unsigned n;
    n = int'(pp_level) * int'(pp_indent);
    return (n > int'(SPACES_MAX)) ? SPACES_MAX : SPACES_W'(n);
  endfunction

  // token for one accepted byte; advances the model state
  function automatic token_t format_byte(input item_t it);
    token_t t;
    logic   was_escaped;
    t          = '0;
    t.out_char = it.in_char;
    if (it.text_start) begin
      clear_nesting();
    end
    was_escaped = pp_escape;
    pp_escape   = 1'b0;
    case (it.in_char)
      CH_BACKSLASH: begin
        if (!was_escaped && pp_in_string) pp_escape = 1'b1;
      end
      CH_COLON: begin
        if (!pp_in_string) t.space_after = 1'b1;
      end
      CH_QUOTE: begin
        if (pp_line_start) begin
          t.newline_before = 1'b1;
          t.spaces_before  = indent_now();
          pp_line_start    = 1'b0;
        end
        if (!was_escaped) pp_in_string = !pp_in_string;
      end
      CH_LBRACE, CH_LBRACKET: begin
        if (!pp_in_string) begin
          // at the limit the depth holds but the line start still counts
          if (pp_level >= MAX_DEPTH) t.depth_fault = 1'b1;
          else pp_level = pp_level + 1'b1;
          pp_line_start = 1'b1;
        end
      end
      CH_RBRACE, CH_RBRACKET: begin
        if (!pp_in_string) begin
          // empty containers close on the same line
          if (pp_prev_char != CH_LBRACE && pp_prev_char != CH_LBRACKET) begin
            t.newline_before = 1'b1;
          end
          if (pp_level == '0) t.depth_fault = 1'b1;
          else pp_level = pp_level - 1'b1;
          if (!pp_line_start) t.spaces_before = indent_now();
          pp_line_start = 1'b0;
        end
      end
      CH_COMMA: begin
        if (!pp_in_string) pp_line_start = 1'b1;
      end
      default: begin
        if (pp_line_start) begin
          t.newline_before = 1'b1;
          t.spaces_before  = indent_now();
          pp_line_start    = 1'b0;
        end
      end
    endcase
    pp_prev_char = it.in_char;
    return t;
  endfunction

  function automatic void flag_field(input string fname, input logic [9:0] want,
                                     input logic [9:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= 40) begin
        $display("%0t ns: %s expected %0d got %0d", $time, fname, want, got);
      end
    end
  endfunction

  // append one byte to the text being built
  function automatic void put_byte(input logic [7:0] ch);
    text_buf = {text_buf, ch};
  endfunction

  // token checker
  always @(posedge clk) begin
    token_t want;
    if (!rst && token_valid === 1'b1 && token_stall === 1'b0) begin
      if (tokens_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 40) begin
          $display("%0t ns: token expected none got char %02h", $time, token.out_char);
        end
      end else begin
        want = tokens_due.pop_front();
        flag_field("newline_before", 10'(want.newline_before), 10'(token.newline_before));
        flag_field("spaces_before", want.spaces_before, token.spaces_before);
        flag_field("out_char", 10'(want.out_char), 10'(token.out_char));
        flag_field("space_after", 10'(want.space_after), 10'(token.space_after));
        flag_field("depth_fault", 10'(want.depth_fault), 10'(token.depth_fault));
      end
    end
  end

  // token receiver: a random stall before each token, none while calm_recv is set
  initial begin
    int unsigned hold;
    token_stall = 1'b0;
    forever begin
      hold = calm_recv ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        @(negedge clk);
        token_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      token_stall <= 1'b0;
      do @(posedge clk); while (rst || token_valid !== 1'b1 || token_stall !== 1'b0);
    end
  end

  // one byte transaction after a random gap; the expected token is queued
  // as it goes out, well ahead of the pipeline
  task automatic send_byte(input logic [7:0] ch, input logic st, input logic typed,
                           input token_t typed_tok);
    item_t       nxt;
    token_t      due;
    int unsigned gap;
    nxt.in_char    = ch;
    nxt.text_start = st;
    gap = calm_send ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= nxt;
    item_valid <= 1'b1;
    due = format_byte(nxt);
    if (typed) due = typed_tok;
    tokens_due = {tokens_due, due};
    do @(posedge clk); while (item_stall !== 1'b0);
    items_sent++;
  endtask

  // stop sending and wait for every outstanding token, plus pipeline slack
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_indent(input logic [INDENT_W-1:0] w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pp_indent = w;
  endtask

  // quoted string with random content, escapes and structural bytes inside
  task automatic add_string();
    logic [7:0] ch;
    put_byte(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 5) == 0) begin
        put_byte(CH_BACKSLASH);
        case ($urandom_range(0, 3))
          0:       ch = CH_QUOTE;
          1:       ch = CH_BACKSLASH;
          2:       ch = 8'h6E;
          default: ch = 8'($urandom_range(0, 255));
        endcase
      end else begin
        ch = 8'($urandom_range(32, 126));
        if (ch == CH_QUOTE || ch == CH_BACKSLASH) ch = CH_COLON;
      end
      put_byte(ch);
    end
    put_byte(CH_QUOTE);
  endtask

  // well-formed nested document of roughly max_len bytes
  task automatic build_document(input int unsigned max_len);
    logic [7:0]  nest [$];
    bit          fresh;
    int unsigned pick;
    text_buf.delete();
    nest = {nest, ($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET)};
    put_byte(nest[$]);
    fresh = 1'b1;
    while (nest.size() != 0) begin
      pick = $urandom_range(0, 5);
      if ((fresh && pick == 0) || (!fresh && pick < 2) || text_buf.size() > max_len) begin
        put_byte(nest[$] == CH_LBRACE ? CH_RBRACE : CH_RBRACKET);
        void'(nest.pop_back());
        fresh = 1'b0;
      end else begin
        if (!fresh) put_byte(CH_COMMA);
        fresh = 1'b0;
        if (nest[$] == CH_LBRACE) begin
          add_string();
          put_byte(CH_COLON);
        end
        pick = $urandom_range(0, 9);
        if (pick < 3 && nest.size() < 8 && text_buf.size() < max_len) begin
          nest = {nest, (pick[0] ? CH_LBRACE : CH_LBRACKET)};
          put_byte(nest[$]);
          fresh = 1'b1;
        end else if (pick < 6) begin
          add_string();
        end else begin
          repeat ($urandom_range(1, 5)) begin
            put_byte(scalar_set[$urandom_range(0, scalar_set.len() - 1)]);
          end
        end
      end
    end
  endtask

  // main sequence
  initial begin
    logic [INDENT_W-1:0] phase_width [NUM_PHASES];
    int unsigned         goal;
    int unsigned         kind;
    int unsigned         n;
    logic                start;
    phase_width = '{4'd0, 4'd15, 4'd1, 4'd9, 4'd5, 4'd3};
    phase_width[3] = 4'($urandom_range(2, 14));
    phase_width[4] = 4'($urandom_range(2, 14));
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    item_valid  = 1'b0;
    item        = '0;
    calm_send   = 1'b0;
    calm_recv   = 1'b0;
    items_sent  = 0;
    err_cnt     = 0;
    pp_indent   = INDENT_DEFAULT;
    clear_nesting();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table at the reset indent width
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].ch, dir_tab[i].st, dir_tab[i].typed, dir_tab[i].tok);
    end

    // random texts, one indent width per phase; each write waits for a drain
    goal = items_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_indent(phase_width[p]);
      goal += RAND_PER_PHASE;
      while (items_sent < goal) begin
        calm_send = ($urandom_range(0, 4) == 0);
        calm_recv = ($urandom_range(0, 4) == 0);
        kind = $urandom_range(0, 99);
        if (kind < 68) begin
          build_document(60);
        end else if (kind < 76) begin
          // deep bracket run: may cross the top limit, may close past zero
          text_buf.delete();
          n = $urandom_range(58, 72);
          repeat (n) put_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
          put_byte(8'h31);
          repeat ($urandom_range(n - 4, n + 3)) begin
            put_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
          end
        end else if (kind < 88) begin
          // damaged document: possibly truncated, and one byte overwritten
          build_document(60);
          n = $urandom_range(1, text_buf.size());
          while (text_buf.size() > n) void'(text_buf.pop_back());
          text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end else begin
          text_buf.delete();
          repeat ($urandom_range(1, 24)) put_byte(8'($urandom_range(0, 255)));
        end
        // now and then a text carries on from the previous one's state
        start = ($urandom_range(0, 7) != 0);
        for (int i = 0; i < text_buf.size(); i++) begin
          send_byte(text_buf[i],
                    (i == 0) ? start : (kind >= 88 && $urandom_range(0, 15) == 0),
                    1'b0, '0);
        end
      end
    end

    calm_recv = 1'b0;
    settle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && tokens_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
